// File: rtl/phvs_pkg.sv
// Shared definitions for the polar histogram valley selector.
// Field widths, register indexes, bus widths and parameter defaults.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package phvs_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_SECTORS     = 36;
   localparam int DEF_SECTOR_DEG  = 10;
   localparam int DEF_MAX_SAMPLES = 4096;

   // Field widths.
   localparam int IDX_W   = 12;
   localparam int RANGE_W = 16;
   localparam int STEP_W  = 12;
   localparam int THR_W   = 28;
   localparam int DEG_W   = 9;

   // Angles in whole degrees.
   localparam int FULL_TURN = 360;
   localparam int HALF_TURN = 180;

   // Bus widths.
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 28;

   // Bit positions within req_tuser.
   localparam int TUSER_OPCODE = 0;
   localparam int TUSER_SCAN   = 1;

   // Opcodes.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ANGLE_STEP = 2'd0,
      CSR_RANGE_MIN  = 2'd1,
      CSR_RANGE_MAX  = 2'd2,
      CSR_THRESHOLD  = 2'd3
   } csr_index_type;

   // Register values after reset.
   localparam logic [STEP_W-1:0]  RST_ANGLE_STEP = 12'd100;
   localparam logic [RANGE_W-1:0] RST_RANGE_MIN  = 16'd100;
   localparam logic [RANGE_W-1:0] RST_RANGE_MAX  = 16'd10000;
   localparam logic [THR_W-1:0]   RST_THRESHOLD  = 28'd100;

   // Saturation value of a sector sum.
   localparam logic [THR_W-1:0] SUM_MAX = {THR_W{1'b1}};

endpackage : phvs_pkg

`default_nettype wire

// File: rtl/polar_histogram_valley_select.sv
// Polar obstacle histogram built from lidar samples, with free-valley selection.
// Depends on phvs_pkg for widths, register indexes and parameter defaults.
// The sector sums are held in one synchronous memory with a registered read.
`default_nettype none

// Usage
// The req channel carries one item per transfer: a lidar sample (opcode 0) or a
// direction query (opcode 1). A sample whose scan_start flag is set clears the
// histogram before its own weight is added. Samples produce no result; every
// query produces exactly one transfer on the rsp channel.
// A sample that adds nothing (invalid, out of the range window or beyond the
// scan) leaves the block idle and ready for the next item. A sample that adds
// weight occupies the block through the reciprocal multiply that finds its
// sector, the correction with the memory read, and the read-modify-write.
// A query occupies the block from its transfer to rsp_tvalid: the memory read
// port scans every sector once, then one sector a cycle is tested for a free
// neighbourhood and compared with the best so far.
// The block works on one item at a time; req_tready is high when it is idle.
// A finished result waits in the output register; if the receiver stalls, the
// block still takes samples, and only a second query holds at its last step
// until the earlier result has been taken.
// Reset (synchronous, active high) restores the registers to their reset values
// and marks every sector as empty at once; there is no clearing pass.
module polar_histogram_valley_select #(
   parameter int SECTORS     = phvs_pkg::DEF_SECTORS,
   parameter int SECTOR_DEG  = phvs_pkg::DEF_SECTOR_DEG,
   parameter int MAX_SAMPLES = phvs_pkg::DEF_MAX_SAMPLES
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // sample_index[11:0], sample_valid[12], range_mm[28:13], target_deg[37:29]
   input  wire logic [phvs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // opcode[0], scan_start[1]
   input  wire logic [phvs_pkg::REQ_TUSER_W-1:0] req_tuser,
   // Result channel.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // front_safe[0], found[1], new_dir_deg[10:2]
   output logic [phvs_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // Configuration write port.
   input  wire logic                             csr_we,
   input  wire logic [phvs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [phvs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import phvs_pkg::*;

   // Sector index width; the scan counter has one bit more to reach SECTORS.
   localparam int SW   = (SECTORS > 1) ? $clog2(SECTORS) : 1;
   // Sample sector = floor(index * step / SDIV), done as a multiply by a
   // reciprocal that may come out one low, then a single correction.
   localparam int PRW  = IDX_W + STEP_W;
   localparam int SDIV = 100 * SECTOR_DEG;
   localparam int SREC = (1 << PRW) / SDIV;
   localparam int SRW  = $clog2(SREC + 1);
   localparam int DW   = $clog2(SDIV + 1);
   localparam int BW   = SRW + 1 + DW;
   localparam int CMPW = (BW > PRW) ? BW : PRW;
   // Target sector = floor(laser_deg / SECTOR_DEG) mod SECTORS, the same way.
   localparam int TREC = (1 << DEG_W) / SECTOR_DEG;
   localparam int TRW  = $clog2(TREC + 1);
   localparam int TN   = (FULL_TURN - 1) / SECTOR_DEG + 1;
   localparam int TQW  = (TN > 1) ? $clog2(TN) : 1;
   localparam int TBW  = TRW + 1 + $clog2(SECTOR_DEG + 1);
   localparam int TCW  = (TBW > DEG_W) ? TBW : DEG_W;
   // Width of sector centres and of their distance to the target.
   localparam int CW0  = $clog2(SECTORS * SECTOR_DEG);
   localparam int DFW  = (CW0 > DEG_W) ? CW0 : DEG_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SDIV,
      ST_SBND,
      ST_SSEC,
      ST_SADD,
      ST_QDIV,
      ST_QFIX,
      ST_QSCAN,
      ST_QPICK,
      ST_QOUT
   } state_type;

   // Request fields.
   logic                  req_opcode;
   logic                  req_scan;
   logic [IDX_W-1:0]      req_idx;
   logic                  req_valid;
   logic [RANGE_W-1:0]    req_range;
   logic [DEG_W-1:0]      req_target;
   logic                  req_xfer;

   assign req_opcode = req_tuser[TUSER_OPCODE];
   assign req_scan   = req_tuser[TUSER_SCAN];
   assign req_idx    = req_tdata[11:0];
   assign req_valid  = req_tdata[12];
   assign req_range  = req_tdata[28:13];
   assign req_target = req_tdata[37:29];

   // Registers and their next values.
   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [RANGE_W-1:0]    rmin_ff, rmin_in;
   logic [RANGE_W-1:0]    rmax_ff, rmax_in;
   logic [THR_W-1:0]      thr_ff, thr_in;
   logic [SECTORS-1:0]    valid_ff, valid_in;
   logic [PRW-1:0]        prod_ff, prod_in;
   logic [RANGE_W-1:0]    weight_ff, weight_in;
   logic [SRW-1:0]        qs_ff, qs_in;
   logic [BW-1:0]         bound_ff, bound_in;
   logic [SW-1:0]         sec_ff, sec_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [DEG_W-1:0]      laser_ff, laser_in;
   logic [TRW-1:0]        qt_ff, qt_in;
   logic [SW-1:0]         tsec_ff, tsec_in;
   logic [SW:0]           scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [SW-1:0]         pidx_ff, pidx_in;
   logic [SECTORS-1:0]    free_ff, free_in;
   logic [SW-1:0]         j_ff, j_in;
   logic [DFW-1:0]        c_ff, c_in;
   logic [DEG_W-1:0]      dir_ff, dir_in;
   logic                  found_ff, found_in;
   logic [DFW-1:0]        bdiff_ff, bdiff_in;
   logic [DEG_W-1:0]      bdir_ff, bdir_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic                  rsp_front_ff, rsp_front_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [DEG_W-1:0]      rsp_dir_ff, rsp_dir_in;

   // Sector memory and its ports.
   logic [THR_W-1:0]      mem [SECTORS];
   logic [THR_W-1:0]      rd_data_ff;
   logic                  mem_re;
   logic [SW-1:0]         mem_raddr;
   logic                  mem_we;
   logic [SW-1:0]         mem_waddr;
   logic [THR_W-1:0]      mem_wdata;

   // Datapath terms.
   logic [PRW+SRW-1:0]    smul;
   logic                  sge;
   logic [SRW:0]          sec_full;
   logic [THR_W-1:0]      old_sum;
   logic [THR_W:0]        new_sum;
   logic [DEG_W+TRW-1:0]  tmul;
   logic [TBW-1:0]        tbound;
   logic                  tge;
   logic [TRW:0]          tq;
   logic [SW-1:0]         tmod [TN];
   logic [DEG_W:0]        tgt_mod;
   logic [DEG_W:0]        laser_sum;
   logic [DFW-1:0]        laser_ext;
   logic [DFW-1:0]        diff;
   logic [DEG_W:0]        dir_next;
   logic [SECTORS-1:0]    valley;
   logic                  keep;

   assign req_xfer = req_tvalid && req_tready;

   // Target sector modulo SECTORS as a constant table over all quotients.
   for (genvar g = 0; g < TN; g++) begin : g_tmod
      assign tmod[g] = SW'(g % SECTORS);
   end

   // A sector heads a free valley when it and two neighbours on each side,
   // wrapping round the histogram, are all below the threshold.
   for (genvar g = 0; g < SECTORS; g++) begin : g_valley
      assign valley[g] = free_ff[(g + 2 * SECTORS - 2) % SECTORS]
                       & free_ff[(g + SECTORS - 1) % SECTORS]
                       & free_ff[g]
                       & free_ff[(g + 1) % SECTORS]
                       & free_ff[(g + 2) % SECTORS];
   end

   always_comb begin
      // Sample arithmetic.
      smul     = (PRW+SRW)'(prod_ff) * (PRW+SRW)'(SREC);
      sge      = CMPW'(prod_ff) >= CMPW'(bound_ff);
      sec_full = {1'b0, qs_ff} + (SRW+1)'(sge);
      old_sum  = rd_vld_ff ? rd_data_ff : '0;
      new_sum  = {1'b0, old_sum} + (THR_W+1)'(weight_ff);
      keep     = req_valid
              && (32'(req_idx) < MAX_SAMPLES)
              && (req_range >= rmin_ff)
              && (req_range <= rmax_ff);

      // Query arithmetic: heading into the laser frame, then its sector.
      tgt_mod   = (req_target >= DEG_W'(FULL_TURN))
                ? (DEG_W+1)'(req_target - DEG_W'(FULL_TURN))
                : (DEG_W+1)'(req_target);
      laser_sum = tgt_mod + (DEG_W+1)'(HALF_TURN);
      tmul      = (DEG_W+TRW)'(laser_ff) * (DEG_W+TRW)'(TREC);
      tbound    = (TBW'(qt_ff) + TBW'(1)) * TBW'(SECTOR_DEG);
      tge       = TCW'(laser_ff) >= TCW'(tbound);
      tq        = {1'b0, qt_ff} + (TRW+1)'(tge);
      laser_ext = DFW'(laser_ff);
      diff      = (c_ff > laser_ext) ? (c_ff - laser_ext) : (laser_ext - c_ff);
      dir_next  = (DEG_W+1)'(dir_ff) + (DEG_W+1)'(SECTOR_DEG);

      // Hold by default.
      state_in      = state_ff;
      step_in       = step_ff;
      rmin_in       = rmin_ff;
      rmax_in       = rmax_ff;
      thr_in        = thr_ff;
      valid_in      = valid_ff;
      prod_in       = prod_ff;
      weight_in     = weight_ff;
      qs_in         = qs_ff;
      bound_in      = bound_ff;
      sec_in        = sec_ff;
      rd_vld_in     = rd_vld_ff;
      laser_in      = laser_ff;
      qt_in         = qt_ff;
      tsec_in       = tsec_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      free_in       = free_ff;
      j_in          = j_ff;
      c_in          = c_ff;
      dir_in        = dir_ff;
      found_in      = found_ff;
      bdiff_in      = bdiff_ff;
      bdir_in       = bdir_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      mem_we        = 1'b0;
      mem_waddr     = sec_ff;
      mem_wdata     = new_sum[THR_W] ? SUM_MAX : new_sum[THR_W-1:0];

      // Configuration writes.
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_ANGLE_STEP: step_in = csr_wdata[STEP_W-1:0];
            CSR_RANGE_MIN:  rmin_in = csr_wdata[RANGE_W-1:0];
            CSR_RANGE_MAX:  rmax_in = csr_wdata[RANGE_W-1:0];
            CSR_THRESHOLD:  thr_in  = csr_wdata[THR_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_opcode == OP_SAMPLE) begin
                  if (req_scan) begin
                     valid_in = '0;
                  end
                  prod_in   = PRW'(req_idx) * PRW'(step_ff);
                  weight_in = rmax_ff - req_range;
                  state_in  = keep ? ST_SDIV : ST_IDLE;
               end else begin
                  laser_in = (laser_sum >= (DEG_W+1)'(FULL_TURN))
                           ? DEG_W'(laser_sum - (DEG_W+1)'(FULL_TURN))
                           : DEG_W'(laser_sum);
                  state_in = ST_QDIV;
               end
            end
         end
         ST_SDIV: begin
            qs_in    = smul[PRW+SRW-1:PRW];
            state_in = ST_SBND;
         end
         ST_SBND: begin
            bound_in = (BW'(qs_ff) + BW'(1)) * BW'(SDIV);
            state_in = ST_SSEC;
         end
         ST_SSEC: begin
            if (sec_full < (SRW+1)'(SECTORS)) begin
               mem_re    = 1'b1;
               mem_raddr = sec_full[SW-1:0];
               rd_vld_in = valid_ff[sec_full[SW-1:0]];
               sec_in    = sec_full[SW-1:0];
               state_in  = ST_SADD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SADD: begin
            mem_we           = 1'b1;
            valid_in[sec_ff] = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_QDIV: begin
            qt_in    = tmul[DEG_W+TRW-1:DEG_W];
            state_in = ST_QFIX;
         end
         ST_QFIX: begin
            tsec_in  = tmod[tq[TQW-1:0]];
            scan_in  = '0;
            j_in     = '0;
            c_in     = '0;
            dir_in   = DEG_W'(HALF_TURN);
            found_in = 1'b0;
            bdiff_in = '0;
            bdir_in  = '0;
            state_in = ST_QSCAN;
         end
         ST_QSCAN: begin
            // Reads are issued back to back; each result is registered and tested while the next read is issued.
            if (pend_ff) begin
               free_in[pidx_ff] = old_sum < thr_ff;
            end
            if (scan_ff != (SW+1)'(SECTORS)) begin
               mem_re    = 1'b1;
               mem_raddr = scan_ff[SW-1:0];
               rd_vld_in = valid_ff[scan_ff[SW-1:0]];
               pend_in   = 1'b1;
               pidx_in   = scan_ff[SW-1:0];
               scan_in   = scan_ff + (SW+1)'(1);
            end else begin
               state_in = ST_QPICK;
            end
         end
         ST_QPICK: begin
            if (valley[j_ff] && (!found_ff || (diff < bdiff_ff))) begin
               found_in = 1'b1;
               bdiff_in = diff;
               bdir_in  = dir_ff;
            end
            j_in   = j_ff + SW'(1);
            c_in   = c_ff + DFW'(SECTOR_DEG);
            dir_in = (dir_next >= (DEG_W+1)'(FULL_TURN))
                   ? DEG_W'(dir_next - (DEG_W+1)'(FULL_TURN))
                   : DEG_W'(dir_next);
            if (j_ff == SW'(SECTORS - 1)) begin
               state_in = ST_QOUT;
            end
         end
         ST_QOUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_front_in  = valley[tsec_ff];
               rsp_found_in  = found_ff;
               rsp_dir_in    = found_ff ? bdir_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= RST_ANGLE_STEP;
         rmin_ff       <= RST_RANGE_MIN;
         rmax_ff       <= RST_RANGE_MAX;
         thr_ff        <= RST_THRESHOLD;
         valid_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rmin_ff       <= rmin_in;
         rmax_ff       <= rmax_in;
         thr_ff        <= thr_in;
         valid_ff      <= valid_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      prod_ff      <= prod_in;
      weight_ff    <= weight_in;
      qs_ff        <= qs_in;
      bound_ff     <= bound_in;
      sec_ff       <= sec_in;
      rd_vld_ff    <= rd_vld_in;
      laser_ff     <= laser_in;
      qt_ff        <= qt_in;
      tsec_ff      <= tsec_in;
      scan_ff      <= scan_in;
      pidx_ff      <= pidx_in;
      free_ff      <= free_in;
      j_ff         <= j_in;
      c_ff         <= c_in;
      dir_ff       <= dir_in;
      found_ff     <= found_in;
      bdiff_ff     <= bdiff_in;
      bdir_ff      <= bdir_in;
      rsp_front_ff <= rsp_front_in;
      rsp_found_ff <= rsp_found_in;
      rsp_dir_ff   <= rsp_dir_in;
   end

   // Sector memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-DEG_W-2){1'b0}}, rsp_dir_ff, rsp_found_ff, rsp_front_ff};

`ifndef SYNTHESIS
   // A scan start leaves every sector empty on the next cycle.
   a_scan_clears: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_opcode == OP_SAMPLE) && req_scan) |=> (valid_ff == '0))
      else $error("histogram not cleared after scan start");

   // A sector written back is marked as holding data.
   a_write_marks: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> valid_ff[$past(mem_waddr)])
      else $error("written sector not marked valid");

   // The valley search starts only once the last scan read has landed.
   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QPICK) |-> !pend_ff)
      else $error("valley search started with a read outstanding");

   // The running heading stays within one turn during the search.
   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QPICK) |-> (dir_ff < DEG_W'(FULL_TURN)))
      else $error("candidate heading out of range");

   // Without a free valley the reported heading is zero.
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_found_ff) |-> (rsp_dir_ff == '0))
      else $error("heading reported without a free valley");
`endif

endmodule : polar_histogram_valley_select

`default_nettype wire
